/* design/small_matrix_multiply_macros.svh */
// Assertion macros shared by the checker of the small matrix multiplier.
// The clock and reset in scope at the point of use must be named clock and reset.
`ifndef SMALL_MATRIX_MULTIPLY_MACROS_SVH
`define SMALL_MATRIX_MULTIPLY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/smm_pkg.sv */
// Package for the small matrix multiplier: sizes, codes, payload types and helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package smm_pkg;

   localparam int MAX_DIM     = 8;
   localparam int ELEM_WIDTH  = 16;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int DIM_W       = $clog2(MAX_DIM + 1);
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int CFG_W       = 4;
   localparam int PROD_W      = 2 * ELEM_WIDTH;
   localparam int CVAL_W      = 35;
   localparam int POS_W       = 3;

   localparam logic [1:0] OP_LOAD_A  = 2'd0;
   localparam logic [1:0] OP_LOAD_B  = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [1:0] CSR_COLS_B    = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [5:0]         elem_index;
      logic signed [15:0] elem_value;
   } req_type;

   typedef struct packed {
      logic signed [CVAL_W-1:0] c_value;
      logic [POS_W-1:0]         c_row;
      logic [POS_W-1:0]         c_col;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } smm_ctl_type;

   function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic signed [ELEM_WIDTH-1:0] to_elem(input logic signed [15:0] v);
      logic signed [31:0] ext;
      ext = 32'(v);
      return ext[ELEM_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/smm_mac.sv */
// Shared multiply-accumulate unit: registered product, then a wrapping accumulator.
// Depends on smm_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module smm_mac
   import smm_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire smm_ctl_type                    ctl,
   input  wire logic signed [ELEM_WIDTH-1:0]   a_data,
   input  wire logic signed [ELEM_WIDTH-1:0]   b_data,
   output logic signed [CVAL_W-1:0]            sum,
   output logic                                done
);

   smm_ctl_type               ctl_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [CVAL_W-1:0]  acc_ff;
   logic signed [CVAL_W-1:0]  acc_in;
   logic                      done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl_ff  <= ctl;
         done_ff <= ctl_ff.valid && ctl_ff.last;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl_ff.valid) begin
         if (ctl_ff.first) begin
            acc_in = CVAL_W'(prod_ff);
         end else begin
            acc_in = acc_ff + CVAL_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_data * b_data;
      acc_ff  <= acc_in;
   end

   assign sum  = acc_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

/* design/small_matrix_multiply.sv */
// Load transfers do not raise req_stall; a compute transfer then holds req_stall high while
// each element of C is formed in turn: its N products are issued through the shared
// multiply-accumulate unit and pass the memory read, product and accumulate stages.
// A compute runs longer if rsp_stall holds results.
// Reset is synchronous and active high; it clears control state and sets the size
// registers to the maximum. The element stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module small_matrix_multiply
   import smm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CFG_W-1:0] csr_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CFG_W-1:0]  rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [IDX_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic [ADDR_W-1:0] a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;
   logic              sum_ready_ff, sum_ready_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   smm_ctl_type       issue_ctl, ctl_ff;

   logic signed [ELEM_WIDTH-1:0] mem_a [STORE_DEPTH];
   logic signed [ELEM_WIDTH-1:0] mem_b [STORE_DEPTH];
   logic signed [ELEM_WIDTH-1:0] a_rd_ff, b_rd_ff;

   logic [DIM_W-1:0]         m_eff, n_eff, l_eff;
   logic                     accept_req, load_ok, rsp_free, sum_avail, emit;
   logic                     k_last, j_last, elem_last;
   logic signed [CVAL_W-1:0] mac_sum;
   logic                     mac_done;

   assign m_eff      = eff_size(rows_a_ff);
   assign n_eff      = eff_size(inner_dim_ff);
   assign l_eff      = eff_size(cols_b_ff);
   assign req_stall  = (state_ff != S_IDLE);
   assign accept_req = req_valid && !req_stall;
   assign load_ok    = (32'(req_data.elem_index) < STORE_DEPTH);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign sum_avail  = sum_ready_ff || mac_done;
   assign k_last     = (DIM_W'(k_ff) == n_eff - DIM_W'(1));
   assign j_last     = (DIM_W'(j_ff) == l_eff - DIM_W'(1));
   assign elem_last  = j_last && (DIM_W'(i_ff) == m_eff - DIM_W'(1));
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      row_base_in  = row_base_ff;
      a_addr_in    = a_addr_ff;
      b_addr_in    = b_addr_ff;
      issue_ctl    = '0;
      emit         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept_req && req_data.operation == OP_COMPUTE) begin
               i_in        = '0;
               j_in        = '0;
               k_in        = '0;
               row_base_in = '0;
               a_addr_in   = '0;
               b_addr_in   = '0;
               state_in    = S_ISSUE;
            end
         end
         S_ISSUE: begin
            issue_ctl.valid = 1'b1;
            issue_ctl.first = (k_ff == '0);
            issue_ctl.last  = k_last;
            k_in      = k_ff + IDX_W'(1);
            a_addr_in = a_addr_ff + ADDR_W'(1);
            b_addr_in = b_addr_ff + ADDR_W'(l_eff);
            if (k_last) begin
               k_in     = '0;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (sum_avail && rsp_free) begin
               emit = 1'b1;
               if (elem_last) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_ISSUE;
                  if (j_last) begin
                     j_in        = '0;
                     i_in        = i_ff + IDX_W'(1);
                     row_base_in = row_base_ff + ADDR_W'(n_eff);
                     a_addr_in   = row_base_ff + ADDR_W'(n_eff);
                     b_addr_in   = '0;
                  end else begin
                     j_in      = j_ff + IDX_W'(1);
                     a_addr_in = row_base_ff;
                     b_addr_in = ADDR_W'(j_ff) + ADDR_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      sum_ready_in = sum_avail && !emit;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_data_in.c_value = mac_sum;
         rsp_data_in.c_row   = POS_W'(i_ff);
         rsp_data_in.c_col   = POS_W'(j_ff);
         rsp_data_in.last    = elem_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctl_ff       <= '0;
         rows_a_ff    <= CFG_W'(MAX_DIM);
         inner_dim_ff <= CFG_W'(MAX_DIM);
         cols_b_ff    <= CFG_W'(MAX_DIM);
      end else begin
         state_ff     <= state_in;
         sum_ready_ff <= sum_ready_in;
         rsp_valid_ff <= rsp_valid_in;
         ctl_ff       <= issue_ctl;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ROWS_A:    rows_a_ff    <= csr_data;
               CSR_INNER_DIM: inner_dim_ff <= csr_data;
               CSR_COLS_B:    cols_b_ff    <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      row_base_ff <= row_base_in;
      a_addr_ff   <= a_addr_in;
      b_addr_ff   <= b_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Element stores: one write port from loads, one registered read port each.
   always_ff @(posedge clock) begin
      if (accept_req && load_ok && req_data.operation == OP_LOAD_A) begin
         mem_a[ADDR_W'(req_data.elem_index)] <= to_elem(req_data.elem_value);
      end
      a_rd_ff <= mem_a[a_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (accept_req && load_ok && req_data.operation == OP_LOAD_B) begin
         mem_b[ADDR_W'(req_data.elem_index)] <= to_elem(req_data.elem_value);
      end
      b_rd_ff <= mem_b[b_addr_ff];
   end

   smm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl_ff),
      .a_data (a_rd_ff),
      .b_data (b_rd_ff),
      .sum    (mac_sum),
      .done   (mac_done)
   );

endmodule

`default_nettype wire

/* design/smm_checker.sv */
// Port-level checker for the small matrix multiplier, bound to the top level.
// Depends on smm_pkg and small_matrix_multiply_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "small_matrix_multiply_macros.svh"

module smm_checker
   import smm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   `SMM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "Stalled result changed or was dropped.")
   `SMM_ASSERT_NEXT(a_compute_busy, req_xfer && req_data.operation == OP_COMPUTE, req_stall, "Compute transfer did not start a run.")
   `SMM_ASSERT_NEXT(a_load_ready, req_xfer && req_data.operation != OP_COMPUTE, !req_stall, "Load transfer left the block busy.")
   `SMM_ASSERT_SAME(a_rsp_in_run, $rose(rsp_valid), $past(req_stall), "Result appeared outside a compute run.")

endmodule

bind small_matrix_multiply smm_checker u_smm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* test/small_matrix_multiply_test.sv */
// Self-checking testbench for the small matrix multiplier: loads A and B, runs
// computes at many sizes and checks every element of C against a local predictor.
// Depends only on smm_pkg and the small_matrix_multiply top level.
`timescale 1ns / 1ps

module small_matrix_multiply_test;
   import smm_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 20;
   localparam int SETTING_QUOTA = 20;

   typedef enum int {VALUES_UNIFORM, VALUES_EDGES, VALUES_MOST_NEGATIVE} value_mix_type;

   class product_scoreboard_type;
      logic signed [15:0] a_store [STORE_DEPTH];
      logic signed [15:0] b_store [STORE_DEPTH];
      bit                 a_written [STORE_DEPTH];
      bit                 b_written [STORE_DEPTH];
      logic [CFG_W-1:0]   size_reg [3];
      rsp_type            c_expected [$];
      int                 errors;

      function new();
         foreach (size_reg[r]) size_reg[r] = CFG_W'(MAX_DIM);
         errors = 0;
      endfunction

      function int dim(logic [1:0] idx);
         int v;
         v = int'(size_reg[idx]);
         if (v == 0) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return v;
      endfunction

      function void set_register(logic [1:0] idx, logic [CFG_W-1:0] value);
         size_reg[idx] = value;
      endfunction

      function int pending();
         return c_expected.size();
      endfunction

      function void note_request(req_type r);
         int m, n, l;
         longint acc;
         rsp_type e;
         case (r.operation)
            OP_LOAD_A: begin
               a_store[r.elem_index] = r.elem_value;
               a_written[r.elem_index] = 1;
            end
            OP_LOAD_B: begin
               b_store[r.elem_index] = r.elem_value;
               b_written[r.elem_index] = 1;
            end
            OP_COMPUTE: begin
               m = dim(CSR_ROWS_A);
               n = dim(CSR_INNER_DIM);
               l = dim(CSR_COLS_B);
               for (int i = 0; i < m; i++) begin
                  for (int j = 0; j < l; j++) begin
                     acc = 0;
                     for (int k = 0; k < n; k++) begin
                        acc += longint'(a_store[i * n + k]) * longint'(b_store[k * l + j]);
                     end
                     e.c_value = acc[CVAL_W-1:0];
                     e.c_row = POS_W'(i);
                     e.c_col = POS_W'(j);
                     e.last = (i == m - 1) && (j == l - 1);
                     c_expected.push_back(e);
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void report(string field, logic signed [63:0] want, logic signed [63:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (c_expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, actual value %0d row %0d col %0d",
                     $time, got.c_value, got.c_row, got.c_col);
            return;
         end
         e = c_expected.pop_front();
         if (got.c_value !== e.c_value) report("c_value", e.c_value, got.c_value);
         if (got.c_row !== e.c_row) report("c_row", e.c_row, got.c_row);
         if (got.c_col !== e.c_col) report("c_col", e.c_col, got.c_col);
         if (got.last !== e.last) report("last", e.last, got.last);
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [1:0]       csr_index;
   logic [CFG_W-1:0] csr_data;

   product_scoreboard_type sb;
   int send_idle;
   int recv_idle;
   int items_sent;
   int quiet_cycles;

   small_matrix_multiply u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic logic signed [15:0] pick_value(value_mix_type mix);
      logic signed [15:0] v;
      v = 16'($urandom);
      if (mix == VALUES_MOST_NEGATIVE) begin
         v = 16'sh8000;
      end else if (mix == VALUES_EDGES) begin
         case ($urandom_range(4))
            0: v = 16'sh8000;
            1: v = 16'sh7fff;
            2: v = 16'sh0000;
            3: v = 16'shffff;
            default: begin
            end
         endcase
      end
      return v;
   endfunction

   task automatic send_request(req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic send_item(logic [1:0] op, int idx, logic signed [15:0] value);
      req_type r;
      r.operation = op;
      r.elem_index = 6'(idx);
      r.elem_value = value;
      send_request(r);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, int value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= CFG_W'(value);
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, CFG_W'(value));
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic configure(int rows, int inner, int cols);
      write_register(CSR_ROWS_A, rows);
      write_register(CSR_INNER_DIM, inner);
      write_register(CSR_COLS_B, cols);
   endtask

   // Entries that a compute reads are written first, since the stores come up undefined.
   task automatic issue_compute(value_mix_type mix);
      int m, n, l;
      m = sb.dim(CSR_ROWS_A);
      n = sb.dim(CSR_INNER_DIM);
      l = sb.dim(CSR_COLS_B);
      for (int idx = 0; idx < m * n; idx++) begin
         if (!sb.a_written[idx]) send_item(OP_LOAD_A, idx, pick_value(mix));
      end
      for (int idx = 0; idx < n * l; idx++) begin
         if (!sb.b_written[idx]) send_item(OP_LOAD_B, idx, pick_value(mix));
      end
      send_item(OP_COMPUTE, $urandom_range(63), 16'($urandom));
   endtask

   task automatic random_batch();
      value_mix_type mix;
      int pick, loads, span, idx;
      logic [1:0] op;
      pick = $urandom_range(9);
      mix = (pick < 6) ? VALUES_UNIFORM : (pick < 9) ? VALUES_EDGES : VALUES_MOST_NEGATIVE;
      loads = $urandom_range(10);
      repeat (loads) begin
         if ($urandom_range(9) == 0) begin
            send_item(OP_UNUSED, $urandom_range(63), 16'($urandom));
         end else begin
            op = $urandom_range(1) ? OP_LOAD_B : OP_LOAD_A;
            span = (op == OP_LOAD_A) ? sb.dim(CSR_ROWS_A) * sb.dim(CSR_INNER_DIM)
                                     : sb.dim(CSR_INNER_DIM) * sb.dim(CSR_COLS_B);
            idx = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(span - 1);
            send_item(op, idx, pick_value(mix));
         end
      end
      issue_compute(mix);
      if ($urandom_range(7) == 0) hold_until_drained();
   endtask

   task automatic run_setting(int rows, int inner, int cols, bit fill_most_negative);
      int start;
      hold_until_drained();
      configure(rows, inner, cols);
      start = items_sent;
      if (fill_most_negative) begin
         for (int idx = 0; idx < STORE_DEPTH; idx++) begin
            send_item(OP_LOAD_A, idx, 16'sh8000);
            send_item(OP_LOAD_B, idx, 16'sh8000);
         end
         issue_compute(VALUES_MOST_NEGATIVE);
      end
      do random_batch(); while (items_sent - start < SETTING_QUOTA);
   endtask

   task automatic directed_items();
      configure(1, 1, 1);
      send_item(OP_LOAD_A, 0, 16'sh8000);
      send_item(OP_LOAD_B, 0, 16'sh8000);
      send_item(OP_COMPUTE, 0, 16'sh0000);
      send_item(OP_LOAD_A, 0, 16'sh7fff);
      send_item(OP_COMPUTE, 0, 16'sh0000);
      send_item(OP_LOAD_B, 0, 16'sh7fff);
      send_item(OP_COMPUTE, 63, 16'shffff);
      // Loads outside the active matrix are still stored.
      send_item(OP_LOAD_A, 63, 16'sh5555);
      send_item(OP_LOAD_B, 63, 16'shaaaa);
      send_item(OP_UNUSED, 42, 16'sh1234);
      send_item(OP_COMPUTE, 21, 16'sh5555);
      send_item(OP_LOAD_A, 0, 16'shffff);
      send_item(OP_LOAD_B, 0, 16'sh0001);
      send_item(OP_COMPUTE, 0, 16'sh0000);
      send_item(OP_LOAD_A, 0, 16'sh0000);
      send_item(OP_COMPUTE, 0, 16'sh0000);
      // A size of zero behaves as a size of one.
      hold_until_drained();
      configure(0, 0, 0);
      send_item(OP_LOAD_A, 0, 16'sh4321);
      send_item(OP_COMPUTE, 0, 16'sh0000);
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      rsp_stall = 0;
      csr_valid = 0;
      csr_index = CSR_ROWS_A;
      csr_data = '0;
      send_idle = 10;
      recv_idle = 81;
      items_sent = 0;
      quiet_cycles = 0;
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      directed_items();
      run_setting(3, 2, 4, 0);
      run_setting(0, 15, 5, 0);

      send_idle = 81;
      recv_idle = 10;
      run_setting(8, 8, 8, 1);
      run_setting(15, 1, 1, 0);

      send_idle = 0;
      recv_idle = 0;
      run_setting(2, 8, 7, 0);
      run_setting($urandom_range(15), $urandom_range(15), $urandom_range(15), 0);

      hold_until_drained();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
